// File: src/kngen_pkg.sv
package kngen_pkg;

    // fixed field geometry
    localparam int LETTER_BITS     = 5;
    localparam int MAX_KMER_LENGTH = 5;
    localparam int ALPHABET_SIZE   = 20;
    localparam int CODE_BITS       = LETTER_BITS * MAX_KMER_LENGTH;
    localparam int LEN_BITS        = 3;
    localparam int THR_BITS        = 10;
    localparam int SCORE_BITS      = 8;
    localparam int SUM_BITS        = 11;
    localparam int ADDR_BITS       = 2 * LETTER_BITS;
    localparam int TABLE_DEPTH     = 1 << ADDR_BITS;
    localparam int IDX_BITS        = $clog2(ALPHABET_SIZE);
    localparam int CFG_DATA_BITS   = THR_BITS;
    localparam int FIFO_DEPTH      = 2;

    // amino-acid codes in scan order
    localparam logic [LETTER_BITS-1:0] AMINO_ORDER [ALPHABET_SIZE] = '{
        5'd0,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,  5'd10, 5'd11,
        5'd12, 5'd13, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd21, 5'd22, 5'd24
    };

    // configuration register indexes
    localparam logic CFG_KMER_LENGTH = 1'b0;
    localparam logic CFG_THRESHOLD   = 1'b1;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        JOB_WRITE,
        JOB_QUERY,
        JOB_NONE
    } t_job_kind;

    typedef struct packed {
        t_job_kind              kind;
        logic [ADDR_BITS-1:0]   addr;
        logic [SCORE_BITS-1:0]  wdata;
        logic [CODE_BITS-1:0]   code;
        logic [LEN_BITS-1:0]    klen;
        logic [LEN_BITS-1:0]    slot;
        logic [LETTER_BITS-1:0] cur;
    } t_job;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BASE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_back_state;

    function automatic logic is_amino(input logic [LETTER_BITS-1:0] letter);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
            if (AMINO_ORDER[i] == letter) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // letter held in a packed slot, slot 0 in the lowest bits
    function automatic logic [LETTER_BITS-1:0] letter_at(
        input logic [CODE_BITS-1:0] code,
        input logic [LEN_BITS-1:0]  slot
    );
        logic [LETTER_BITS-1:0] res;
        res = '0;
        for (int s = 0; s < MAX_KMER_LENGTH; s++) begin
            if (slot == LEN_BITS'(s)) begin
                res = code[s*LETTER_BITS +: LETTER_BITS];
            end
        end
        return res;
    endfunction

    function automatic logic [CODE_BITS-1:0] replace_letter(
        input logic [CODE_BITS-1:0]   code,
        input logic [LEN_BITS-1:0]    slot,
        input logic [LETTER_BITS-1:0] letter
    );
        logic [CODE_BITS-1:0] res;
        res = code;
        for (int s = 0; s < MAX_KMER_LENGTH; s++) begin
            if (slot == LEN_BITS'(s)) begin
                res[s*LETTER_BITS +: LETTER_BITS] = letter;
            end
        end
        return res;
    endfunction

endpackage

// File: src/kngen_ram.sv
module kngen_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/kngen_front.sv
module kngen_front (
    input  logic                                 i_start,
    input  logic                                 i_operation,
    input  logic [kngen_pkg::LETTER_BITS-1:0]    i_row_letter,
    input  logic [kngen_pkg::LETTER_BITS-1:0]    i_col_letter,
    input  logic signed [kngen_pkg::SCORE_BITS-1:0] i_entry_score,
    input  logic [kngen_pkg::CODE_BITS-1:0]      i_kmer_code,
    input  logic [kngen_pkg::LEN_BITS-1:0]       i_position,
    input  logic [kngen_pkg::LEN_BITS-1:0]       i_kmer_length,
    input  logic [kngen_pkg::THR_BITS-1:0]       i_score_threshold,
    input  logic                                 i_fifo_full,
    input  kngen_pkg::t_back_status              i_status,
    output logic                                 o_busy,
    output logic                                 o_push,
    output kngen_pkg::t_job                      o_job
);

    logic [kngen_pkg::LEN_BITS-1:0]    k_eff;
    logic [kngen_pkg::CODE_BITS-1:0]   masked;
    logic [kngen_pkg::LEN_BITS-1:0]    slot;
    logic [kngen_pkg::LETTER_BITS-1:0] cur;
    logic                              no_result;

    always_comb begin
        // lengths above the maximum saturate
        if (i_kmer_length > kngen_pkg::LEN_BITS'(kngen_pkg::MAX_KMER_LENGTH)) begin
            k_eff = kngen_pkg::LEN_BITS'(kngen_pkg::MAX_KMER_LENGTH);
        end else begin
            k_eff = i_kmer_length;
        end

        // drop residues above the k-mer
        masked = '0;
        for (int s = 0; s < kngen_pkg::MAX_KMER_LENGTH; s++) begin
            if (kngen_pkg::LEN_BITS'(s) < k_eff) begin
                masked[s*kngen_pkg::LETTER_BITS +: kngen_pkg::LETTER_BITS] =
                    i_kmer_code[s*kngen_pkg::LETTER_BITS +: kngen_pkg::LETTER_BITS];
            end
        end

        // first residue sits in the highest slot
        slot = kngen_pkg::LEN_BITS'(k_eff - i_position - kngen_pkg::LEN_BITS'(1));
        cur  = kngen_pkg::letter_at(masked, slot);

        no_result = (k_eff == '0) || (i_position >= k_eff) ||
                    (i_score_threshold == '0) || !kngen_pkg::is_amino(cur);

        o_job.addr  = {i_row_letter, i_col_letter};
        o_job.wdata = i_entry_score;
        o_job.code  = masked;
        o_job.klen  = k_eff;
        o_job.slot  = slot;
        o_job.cur   = cur;
        if (i_operation == kngen_pkg::OP_WRITE) begin
            o_job.kind = kngen_pkg::JOB_WRITE;
        end else if (no_result) begin
            o_job.kind = kngen_pkg::JOB_NONE;
        end else begin
            o_job.kind = kngen_pkg::JOB_QUERY;
        end
    end

    assign o_busy = i_fifo_full | i_status.clearing;
    assign o_push = i_start & ~o_busy;

endmodule

// File: src/kngen_fifo.sv
module kngen_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  kngen_pkg::t_job i_job,
    input  logic            i_pop,
    output kngen_pkg::t_job o_job,
    output logic            o_full,
    output logic            o_empty
);

    localparam int PTR_BITS = $clog2(kngen_pkg::FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(kngen_pkg::FIFO_DEPTH + 1);

    kngen_pkg::t_job     r_mem [kngen_pkg::FIFO_DEPTH];
    logic [PTR_BITS-1:0] r_wptr, n_wptr;
    logic [PTR_BITS-1:0] r_rptr, n_rptr;
    logic [CNT_BITS-1:0] r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_BITS'(kngen_pkg::FIFO_DEPTH - 1)) ?
                     '0 : PTR_BITS'(r_wptr + 1'b1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_BITS'(kngen_pkg::FIFO_DEPTH - 1)) ?
                     '0 : PTR_BITS'(r_rptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = CNT_BITS'(r_count + 1'b1);
        end else if (!i_push && i_pop) begin
            n_count = CNT_BITS'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rptr];
    assign o_full  = (r_count == CNT_BITS'(kngen_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);

endmodule

// File: src/kngen_back.sv
module kngen_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [kngen_pkg::THR_BITS-1:0]       i_threshold,
    input  logic                                 i_fifo_empty,
    input  kngen_pkg::t_job                      i_job,
    output logic                                 o_pop,
    output kngen_pkg::t_back_status              o_status,
    output logic                                 o_result_valid,
    output logic [kngen_pkg::CODE_BITS-1:0]      o_neighbor_code,
    output logic signed [kngen_pkg::SUM_BITS-1:0] o_neighbor_score,
    output logic                                 o_found,
    output logic                                 o_last
);

    kngen_pkg::t_back_state r_state, n_state;
    logic [kngen_pkg::ADDR_BITS-1:0]   r_clr_addr, n_clr_addr;
    kngen_pkg::t_job                   r_job, n_job;
    logic [kngen_pkg::LEN_BITS-1:0]    r_slot, n_slot;
    logic [kngen_pkg::IDX_BITS-1:0]    r_idx, n_idx;
    logic                              r_rd_vld, n_rd_vld;
    logic                              r_rd_sub, n_rd_sub;
    logic [kngen_pkg::LETTER_BITS-1:0] r_rd_letter, n_rd_letter;
    logic signed [kngen_pkg::SUM_BITS-1:0] r_base, n_base;
    logic                              r_pend_vld, n_pend_vld;
    logic [kngen_pkg::CODE_BITS-1:0]   r_pend_code, n_pend_code;
    logic signed [kngen_pkg::SUM_BITS-1:0] r_pend_score, n_pend_score;
    logic                              r_out_vld, n_out_vld;
    logic [kngen_pkg::CODE_BITS-1:0]   r_out_code, n_out_code;
    logic signed [kngen_pkg::SUM_BITS-1:0] r_out_score, n_out_score;
    logic                              r_out_found, n_out_found;
    logic                              r_out_last, n_out_last;

    logic                               ram_we;
    logic [kngen_pkg::ADDR_BITS-1:0]    ram_waddr;
    logic [kngen_pkg::SCORE_BITS-1:0]   ram_wdata;
    logic [kngen_pkg::ADDR_BITS-1:0]    ram_raddr;
    logic [kngen_pkg::SCORE_BITS-1:0]   ram_rdata;
    logic signed [kngen_pkg::SCORE_BITS-1:0] rd_score;
    logic signed [kngen_pkg::SUM_BITS-1:0]   sum;
    logic [kngen_pkg::LETTER_BITS-1:0]  base_letter;
    logic [kngen_pkg::LETTER_BITS-1:0]  aa;

    kngen_ram #(
        .WIDTH (kngen_pkg::SCORE_BITS),
        .DEPTH (kngen_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_score    = ram_rdata;
    assign sum         = r_base + kngen_pkg::SUM_BITS'(rd_score);
    assign base_letter = kngen_pkg::letter_at(r_job.code, r_slot);
    assign aa          = kngen_pkg::AMINO_ORDER[r_idx];

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_job        = r_job;
        n_slot       = r_slot;
        n_idx        = r_idx;
        n_rd_vld     = 1'b0;
        n_rd_sub     = 1'b0;
        n_rd_letter  = r_rd_letter;
        n_base       = r_base;
        n_pend_vld   = r_pend_vld;
        n_pend_code  = r_pend_code;
        n_pend_score = r_pend_score;
        n_out_vld    = 1'b0;
        n_out_code   = r_out_code;
        n_out_score  = r_out_score;
        n_out_found  = r_out_found;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = r_clr_addr;
        ram_wdata    = '0;
        ram_raddr    = {r_job.cur, aa};
        o_pop        = 1'b0;

        // score read issued last cycle
        if (r_rd_vld) begin
            if (!r_rd_sub) begin
                n_base = sum;
            end else if (sum >= $signed({1'b0, i_threshold})) begin
                if (r_pend_vld) begin
                    n_out_vld   = 1'b1;
                    n_out_code  = r_pend_code;
                    n_out_score = r_pend_score;
                    n_out_found = 1'b1;
                    n_out_last  = 1'b0;
                end
                n_pend_vld   = 1'b1;
                n_pend_code  = kngen_pkg::replace_letter(r_job.code, r_job.slot, r_rd_letter);
                n_pend_score = sum;
            end
        end

        case (r_state)
            kngen_pkg::ST_CLEAR: begin
                ram_we     = 1'b1;
                n_clr_addr = kngen_pkg::ADDR_BITS'(r_clr_addr + 1'b1);
                if (r_clr_addr == kngen_pkg::ADDR_BITS'(kngen_pkg::TABLE_DEPTH - 1)) begin
                    n_state = kngen_pkg::ST_IDLE;
                end
            end
            kngen_pkg::ST_IDLE: begin
                if (!i_fifo_empty) begin
                    o_pop = 1'b1;
                    case (i_job.kind)
                        kngen_pkg::JOB_WRITE: begin
                            ram_we    = 1'b1;
                            ram_waddr = i_job.addr;
                            ram_wdata = i_job.wdata;
                        end
                        kngen_pkg::JOB_QUERY: begin
                            n_job   = i_job;
                            n_slot  = '0;
                            n_base  = '0;
                            n_state = kngen_pkg::ST_BASE;
                        end
                        default: begin
                            n_out_vld   = 1'b1;
                            n_out_code  = '0;
                            n_out_score = '0;
                            n_out_found = 1'b0;
                            n_out_last  = 1'b1;
                        end
                    endcase
                end
            end
            kngen_pkg::ST_BASE: begin
                // diagonal score of each unchanged residue
                ram_raddr = {base_letter, base_letter};
                if (r_slot != r_job.slot) begin
                    n_rd_vld = 1'b1;
                end
                n_slot = kngen_pkg::LEN_BITS'(r_slot + 1'b1);
                if (r_slot == kngen_pkg::LEN_BITS'(r_job.klen - 1'b1)) begin
                    n_idx   = '0;
                    n_state = kngen_pkg::ST_SCAN;
                end
            end
            kngen_pkg::ST_SCAN: begin
                if (aa != r_job.cur) begin
                    n_rd_vld    = 1'b1;
                    n_rd_sub    = 1'b1;
                    n_rd_letter = aa;
                end
                n_idx = kngen_pkg::IDX_BITS'(r_idx + 1'b1);
                if (r_idx == kngen_pkg::IDX_BITS'(kngen_pkg::ALPHABET_SIZE - 1)) begin
                    n_idx   = '0;
                    n_state = kngen_pkg::ST_DRAIN;
                end
            end
            kngen_pkg::ST_DRAIN: begin
                n_state = kngen_pkg::ST_FINISH;
            end
            kngen_pkg::ST_FINISH: begin
                n_out_vld  = 1'b1;
                n_out_last = 1'b1;
                if (r_pend_vld) begin
                    n_out_code  = r_pend_code;
                    n_out_score = r_pend_score;
                    n_out_found = 1'b1;
                end else begin
                    n_out_code  = '0;
                    n_out_score = '0;
                    n_out_found = 1'b0;
                end
                n_pend_vld = 1'b0;
                n_state    = kngen_pkg::ST_IDLE;
            end
            default: begin
                n_state = kngen_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= kngen_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_rd_vld   <= n_rd_vld;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job        <= n_job;
        r_slot       <= n_slot;
        r_idx        <= n_idx;
        r_rd_sub     <= n_rd_sub;
        r_rd_letter  <= n_rd_letter;
        r_base       <= n_base;
        r_pend_code  <= n_pend_code;
        r_pend_score <= n_pend_score;
        r_out_code   <= n_out_code;
        r_out_score  <= n_out_score;
        r_out_found  <= n_out_found;
        r_out_last   <= n_out_last;
    end

    assign o_status.clearing = (r_state == kngen_pkg::ST_CLEAR);
    assign o_result_valid    = r_out_vld;
    assign o_neighbor_code   = r_out_code;
    assign o_neighbor_score  = r_out_score;
    assign o_found           = r_out_found;
    assign o_last            = r_out_last;

endmodule

// File: src/kmer_neighbor_generator_unit.sv
// channel   | direction | handshake                          | payload
// ----------+-----------+------------------------------------+---------------------------------
// item in   | in        | i_start, o_busy (taken: start&!busy)| operation, letters, score, k-mer
// result    | out       | o_result_valid, one-cycle strobe    | neighbor code/score, found, last
// config    | in        | i_cfg_valid, o_cfg_ready            | i_cfg_index, i_cfg_data
//
// a table write is done by the back end as it pops the item; a query reads the diagonal score of
// each unchanged residue, then one score per amino acid through the single table read port
// after reset a clearing pass over all 1024 table entries zeroes the score table; o_busy stays high
// the two-entry item queue lets one or two items wait while a query runs
// results are strobed for one cycle and must be taken; nothing stalls the output
module kmer_neighbor_generator_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // item channel
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic                                 i_operation,
    input  logic [kngen_pkg::LETTER_BITS-1:0]    i_row_letter,
    input  logic [kngen_pkg::LETTER_BITS-1:0]    i_col_letter,
    input  logic signed [kngen_pkg::SCORE_BITS-1:0] i_entry_score,
    input  logic [kngen_pkg::CODE_BITS-1:0]      i_kmer_code,
    input  logic [kngen_pkg::LEN_BITS-1:0]       i_position,
    // result channel
    output logic                                 o_result_valid,
    output logic [kngen_pkg::CODE_BITS-1:0]      o_neighbor_code,
    output logic signed [kngen_pkg::SUM_BITS-1:0] o_neighbor_score,
    output logic                                 o_found,
    output logic                                 o_last,
    // configuration channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic                                 i_cfg_index,
    input  logic [kngen_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    // configuration registers
    logic [kngen_pkg::LEN_BITS-1:0] r_kmer_length;
    logic [kngen_pkg::THR_BITS-1:0] r_score_threshold;

    // front to queue
    logic            push;
    kngen_pkg::t_job push_job;
    // queue to back
    logic            pop;
    logic            fifo_full;
    logic            fifo_empty;
    kngen_pkg::t_job head_job;
    // back end status seen by the front
    kngen_pkg::t_back_status back_status;

    // always able to take a register write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length     <= kngen_pkg::LEN_BITS'(4);
            r_score_threshold <= kngen_pkg::THR_BITS'(13);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                kngen_pkg::CFG_KMER_LENGTH: begin
                    r_kmer_length <= i_cfg_data[kngen_pkg::LEN_BITS-1:0];
                end
                kngen_pkg::CFG_THRESHOLD: begin
                    r_score_threshold <= i_cfg_data[kngen_pkg::THR_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // classify: table write, real query, or a query with no possible neighbor
    kngen_front u_front (
        .i_start           (i_start),
        .i_operation       (i_operation),
        .i_row_letter      (i_row_letter),
        .i_col_letter      (i_col_letter),
        .i_entry_score     (i_entry_score),
        .i_kmer_code       (i_kmer_code),
        .i_position        (i_position),
        .i_kmer_length     (r_kmer_length),
        .i_score_threshold (r_score_threshold),
        .i_fifo_full       (fifo_full),
        .i_status          (back_status),
        .o_busy            (o_busy),
        .o_push            (push),
        .o_job             (push_job)
    );

    // short item queue between front and back
    kngen_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    // table owner: clearing pass, writes, base sum and substitution scan
    kngen_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_threshold      (r_score_threshold),
        .i_fifo_empty     (fifo_empty),
        .i_job            (head_job),
        .o_pop            (pop),
        .o_status         (back_status),
        .o_result_valid   (o_result_valid),
        .o_neighbor_code  (o_neighbor_code),
        .o_neighbor_score (o_neighbor_score),
        .o_found          (o_found),
        .o_last           (o_last)
    );

endmodule

// File: src/kngen_checker.sv
module kngen_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_busy,
    input  logic                                 o_result_valid,
    input  logic [kngen_pkg::CODE_BITS-1:0]      o_neighbor_code,
    input  logic signed [kngen_pkg::SUM_BITS-1:0] o_neighbor_score,
    input  logic                                 o_found,
    input  logic                                 o_last
);

    // empty result closes its query and carries zeros
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_found |-> o_last && o_neighbor_code == '0 &&
                                       o_neighbor_score == '0)
        else $error("empty result not final or not zero");

    // a reported neighbor always cleared a positive threshold
    a_found_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_found |-> o_neighbor_score > 0)
        else $error("neighbor reported with non-positive score");

    // reset starts the table clear: busy and no result right after
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> o_busy && !o_result_valid)
        else $error("block not busy after reset");

endmodule

bind kmer_neighbor_generator_unit kngen_checker u_checker (.*);
